/* hdl/b64ld_pkg.sv */
package b64ld_pkg;

  localparam logic [7:0] LINE_FEED       = 8'd10;
  localparam logic [7:0] MAX_BYTES_RESET = 8'd184;
  localparam logic [7:0] SAT_MAX         = 8'd255;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } result_kind_e;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  // Maps one character of the Base64 alphabet to its 6-bit value.
  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (ch == 8'h2F) begin
      s.value = 6'd63;
    end else if (ch == 8'h2B) begin
      s.value = 6'd62;
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      s.value = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s.value = 6'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.value = 6'(ch - 8'h30 + 8'd52);
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

/* hdl/base64_line_decoder_core.sv */
// Streaming Base64 line decoder. One ASCII character is taken per beat on the
// slave side; a line feed ends the line. Each complete byte leaves as a data
// beat, a line feed as an end beat carrying the byte count unless discarding,
// and an invalid character or one that would exceed max_bytes as an error beat
// carrying its 1-based position, after which characters are dropped until the
// next line feed. Padding is not supported. The block takes one character
// every cycle unless the output stalls: decoding is a single pass of table
// lookup and shifting between the line state registers and the output register,
// which lets a new character in during the same cycle the held result is taken.
module base64_line_decoder_core
  import b64ld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] count_or_position
  output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);

  logic [7:0]   max_bytes_q;
  logic [1:0]   phase_q, phase_d;
  logic [7:0]   partial_q, partial_d;
  logic [7:0]   chars_q, chars_d;
  logic [7:0]   bytes_q, bytes_d;
  logic         discard_q, discard_d;
  logic         out_valid_q, out_valid_d;
  result_kind_e kind_q, kind_d;
  logic [7:0]   data_q, data_d;
  logic [7:0]   num_q, num_d;
  logic         accept;
  logic         emit;
  sextet_t      sx;
  logic [7:0]   err_pos;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sx            = sextet_of(s_axis_tdata);
  assign err_pos       = (chars_q == SAT_MAX) ? SAT_MAX : chars_q + 8'd1;

  always_comb begin
    phase_d   = phase_q;
    partial_d = partial_q;
    chars_d   = chars_q;
    bytes_d   = bytes_q;
    discard_d = discard_q;
    emit      = 1'b0;
    kind_d    = KIND_DATA;
    data_d    = 8'd0;
    num_d     = 8'd0;
    if (s_axis_tdata == LINE_FEED) begin
      if (!discard_q) begin
        emit   = 1'b1;
        kind_d = KIND_END;
        num_d  = bytes_q;
      end
      phase_d   = 2'd0;
      partial_d = 8'd0;
      chars_d   = 8'd0;
      bytes_d   = 8'd0;
      discard_d = 1'b0;
    end else if (discard_q) begin
      emit = 1'b0;
    end else if (bytes_q >= max_bytes_q || !sx.valid) begin
      // Overflow is checked before validity of the character.
      emit      = 1'b1;
      kind_d    = KIND_ERROR;
      num_d     = err_pos;
      discard_d = 1'b1;
    end else begin
      case (phase_q)
        2'd0: begin
          partial_d = {sx.value, 2'b00};
        end
        2'd1: begin
          emit      = 1'b1;
          data_d    = partial_q | {6'd0, sx.value[5:4]};
          partial_d = {sx.value[3:0], 4'd0};
        end
        2'd2: begin
          emit      = 1'b1;
          data_d    = partial_q | {4'd0, sx.value[5:2]};
          partial_d = {sx.value[1:0], 6'd0};
        end
        default: begin
          emit      = 1'b1;
          data_d    = partial_q | {2'd0, sx.value};
          partial_d = 8'd0;
        end
      endcase
      phase_d = phase_q + 2'd1;
      if (chars_q != SAT_MAX) begin
        chars_d = chars_q + 8'd1;
      end
      if (emit && bytes_q != SAT_MAX) begin
        bytes_d = bytes_q + 8'd1;
      end
    end
  end

  always_comb begin
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MAX_BYTES_RESET;
      phase_q     <= 2'd0;
      partial_q   <= 8'd0;
      chars_q     <= 8'd0;
      bytes_q     <= 8'd0;
      discard_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_bytes_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q   <= phase_d;
        partial_q <= partial_d;
        chars_q   <= chars_d;
        bytes_q   <= bytes_d;
        discard_q <= discard_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q <= kind_d;
      data_q <= data_d;
      num_q  <= num_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {num_q, data_q};
  assign m_axis_tuser  = kind_q;

endmodule

/* dv/tb_base64_line_decoder_core.sv */
`timescale 1ns / 100ps

module tb_base64_line_decoder_core
  import b64ld_pkg::*;
();

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_CHARS  = 1700;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    result_kind_e kind;
    logic [7:0]   data;
    logic [7:0]   num;
  } decoded_beat_t;

  // Tracks the line state of the decoder and holds the beats it owes.
  class line_scoreboard;
    decoded_beat_t owed_q[$];
    logic [7:0]    max_bytes;
    logic [1:0]    group_phase;
    logic [7:0]    partial_bits;
    logic [7:0]    chars_seen;
    logic [7:0]    bytes_out;
    bit            discarding;
    int            errors;
    int            chars_in;
    int            n_data;
    int            n_end;
    int            n_error;

    function new();
      max_bytes = MAX_BYTES_RESET;
      clear_line();
    endfunction

    function void clear_line();
      group_phase  = 2'd0;
      partial_bits = 8'd0;
      chars_seen   = 8'd0;
      bytes_out    = 8'd0;
      discarding   = 1'b0;
    endfunction

    function int sextet_value(logic [7:0] ch);
      if (ch == "/") return 63;
      if (ch == "+") return 62;
      if (ch >= "A" && ch <= "Z") return int'(ch) - "A";
      if (ch >= "a" && ch <= "z") return int'(ch) - "a" + 26;
      if (ch >= "0" && ch <= "9") return int'(ch) - "0" + 52;
      return -1;
    endfunction

    function void owe(result_kind_e kind, logic [7:0] data, logic [7:0] num);
      decoded_beat_t b;
      b.kind = kind;
      b.data = data;
      b.num  = num;
      owed_q.push_back(b);
    endfunction

    function void note_char(logic [7:0] ch);
      int         v;
      logic [7:0] byte_val;
      logic [7:0] pos;
      logic [1:0] ph;
      chars_in++;
      pos = (chars_seen == SAT_MAX) ? SAT_MAX : chars_seen + 8'd1;
      if (ch == LINE_FEED) begin
        if (!discarding) owe(KIND_END, 8'd0, bytes_out);
        clear_line();
        return;
      end
      if (discarding) return;
      v = sextet_value(ch);
      // A full line reports overflow even for characters outside the alphabet.
      if (bytes_out >= max_bytes || v < 0) begin
        owe(KIND_ERROR, 8'd0, pos);
        discarding = 1'b1;
        return;
      end
      ph = group_phase;
      byte_val = 8'd0;
      case (ph)
        2'd0: begin
          partial_bits = 8'(v << 2);
        end
        2'd1: begin
          byte_val     = partial_bits | 8'(v >> 4);
          partial_bits = 8'(v << 4);
        end
        2'd2: begin
          byte_val     = partial_bits | 8'(v >> 2);
          partial_bits = 8'(v << 6);
        end
        default: begin
          byte_val     = partial_bits | 8'(v);
          partial_bits = 8'd0;
        end
      endcase
      group_phase = ph + 2'd1;
      if (chars_seen != SAT_MAX) chars_seen++;
      if (ph != 2'd0) begin
        if (bytes_out != SAT_MAX) bytes_out++;
        owe(KIND_DATA, byte_val, 8'd0);
      end
    endfunction

    function void check_beat(logic [1:0] kind, logic [7:0] data, logic [7:0] num);
      decoded_beat_t b;
      if (owed_q.size() == 0) begin
        $error("unexpected beat: result_kind %0d data_byte %0d count_or_position %0d",
               kind, data, num);
        errors++;
        return;
      end
      b = owed_q.pop_front();
      if (kind != b.kind) begin
        $error("result_kind: expected %0d, actual %0d", b.kind, kind);
        errors++;
      end
      if (data != b.data) begin
        $error("data_byte: expected %0d, actual %0d", b.data, data);
        errors++;
      end
      if (num != b.num) begin
        $error("count_or_position: expected %0d, actual %0d", b.num, num);
        errors++;
      end
      case (b.kind)
        KIND_DATA: n_data++;
        KIND_END:  n_end++;
        default:   n_error++;
      endcase
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] data_byte, [15:8] count_or_position
  logic [1:0]  m_axis_tuser;   // [1:0] result_kind

  line_scoreboard sb = new();
  bit             idle_on = 1'b1;
  int             cycles  = 0;
  int             n_settings = 1;

  base64_line_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Input beats are noted before output beats so the order within an edge is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_char(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_beat(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, sb.owed_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [7:0] base64_char(int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? 8'("+") : 8'("/");
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (sb.sextet_value(c) >= 0 || c == LINE_FEED);
    return c;
  endfunction

  // Leaves valid high after the beat so back-to-back beats need no toggle.
  task automatic send_char(logic [7:0] c);
    while (idle_on && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_max_bytes(logic [7:0] m);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.max_bytes = m;
    n_settings++;
  endtask

  task automatic send_valid_run(int n);
    for (int i = 0; i < n; i++) send_char(base64_char($urandom_range(63)));
  endtask

  task automatic send_random_line();
    int mode;
    int len;
    int bad_at;
    mode = $urandom_range(99);
    if (mode < 85) begin
      if ($urandom_range(9) == 0) len = $urandom_range(0, (int'(sb.max_bytes) * 4) / 3 + 6);
      else len = $urandom_range(0, 20);
      bad_at = -1;
      if (mode >= 70) begin
        if (len == 0) len = 1;
        bad_at = $urandom_range(0, len - 1);
      end
      for (int i = 0; i < len; i++) begin
        if (i == bad_at) send_char(bad_char());
        else send_char(base64_char($urandom_range(63)));
      end
    end else begin
      len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++) send_char(8'($urandom_range(255)));
    end
    send_char(LINE_FEED);
  endtask

  initial begin
    logic [7:0] settings [5];
    int         start;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    m_axis_tready = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Whole alphabet corners, an empty line and an unfinished group.
    send_text("AZaz09+/\n");
    send_text("\n");
    send_text("Q\n");
    // Errors on the lowest and highest codes; later characters and the line
    // feed are swallowed while discarding.
    send_text("Q");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("A\n");
    send_char(8'hFF);
    send_char(LINE_FEED);
    send_text("=\n");

    settings[0] = 8'd1;
    settings[1] = 8'd191;
    settings[2] = 8'($urandom_range(2, 60));
    settings[3] = 8'($urandom_range(61, 190));
    settings[4] = MAX_BYTES_RESET;
    for (int p = 0; p < 5; p++) begin
      set_max_bytes(settings[p]);
      idle_on = (p != 3);
      start = sb.chars_in;
      if (settings[p] == 8'd191) begin
        // Fill the line to exactly the limit so positions saturate at 255.
        send_valid_run(255);
        send_char(($urandom_range(1) == 0) ? base64_char($urandom_range(63)) : bad_char());
        send_char(LINE_FEED);
        send_valid_run(254);
        send_char(bad_char());
        send_char(LINE_FEED);
      end
      while (sb.chars_in - start < RANDOM_CHARS / 5) send_random_line();
    end
    idle_on = 1'b1;

    wait_drain();
    repeat (16) @(negedge clk_i);
    $display("%0d characters over %0d max_bytes settings, idle and back-to-back traffic",
             sb.chars_in, n_settings);
    $display("checked %0d data, %0d line-end and %0d error beats, %0d mismatches",
             sb.n_data, sb.n_end, sb.n_error, sb.errors);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
